// ===== rtl/sobel_edge_threshold_macros.svh =====
// ----------------------------------------------------------------------------
// sobel edge threshold assertion macros
// concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

`ifndef SYNTH
// condition on one cycle implies consequence on the same cycle
`define SOBEL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// condition on one cycle implies consequence on the next cycle
`define SOBEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOBEL_ASSERT_IMP(label, ante, cons, msg)
`define SOBEL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/sobel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_pkg
// types and constants shared by the sobel edge threshold block
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 4'd3;

  // arithmetic widths
  localparam int GRAD_W   = 11;
  localparam int SUMSQ_W  = 21;
  localparam int RAD_W    = 38;
  localparam int ROOT_W   = 19;
  localparam int REM_W    = 22;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 20;
  localparam int PROD_W   = ROOT_W + GAIN_W;
  localparam int SCALED_W = PROD_W - 8;

  // window pixels, index row*3 + column
  typedef logic [8:0][PIX_W-1:0] pix_win_t;

  // which results an item causes
  typedef struct packed {
    logic corner;
    logic bottom;
    logic right;
    logic main;
    logic interior;
  } job_flags_t;

  localparam int JOB_FLAGS_W = $bits(job_flags_t);

  typedef enum logic [1:0] {
    F_IDLE,
    F_EXEC,
    F_WAIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GRAD,
    B_SQR,
    B_ROOT,
    B_MUL,
    B_THR,
    B_EMIT
  } back_state_t;

endpackage

// ===== rtl/pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pix_if
// pixel stream channel with valid and ready
// ----------------------------------------------------------------------------
interface pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ===== rtl/res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// res_if
// edge result channel with valid and ready
// ----------------------------------------------------------------------------
interface res_if #(
  parameter int CW = 11,
  parameter int RW = 12
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic [7:0]    edge_value;
  logic          last_of_run;
  logic          frame_done;

  modport source (output valid, output out_col, output out_row, output edge_value,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input out_col, input out_row, input edge_value,
                input last_of_run, input frame_done, output ready);
endinterface

// ===== rtl/cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfg_if
// register write channel with valid and ready
// ----------------------------------------------------------------------------
interface cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sobel_edge_threshold.sv =====
// front: accept, line store update, read of the next column, then the next pixel
// back: gradient, square, 19-step bit-serial square root, gain, threshold, emit;
// border-only items skip to emit; up to 4 results per item, one per cycle while the
// output is free; the front waits while the two-entry job queue is full
// reset: synchronous active low; counters and window cleared, registers 640/480/0/256,
// line stores are not cleared
`timescale 1ns / 1ps
`include "sobel_edge_threshold_macros.svh"
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// streaming 3x3 sobel edge detector with gain and threshold
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic  clk,
  input  logic  rst_n,
  pix_if.sink   in_ch,
  res_if.source out_ch,
  cfg_if.sink   cfg_ch
);
  import sobel_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = JOB_FLAGS_W + $bits(pix_win_t) + CW + RW;

  logic [11:0]       fw_r;
  logic [12:0]       fh_r;
  logic [THR_W-1:0]  thr_r;
  logic [GAIN_W-1:0] gain_r;
  logic [CW-1:0]     wm1;
  logic [RW-1:0]     hm1;

  logic              push, q_ready, pop, pop_valid;
  job_flags_t        job_flags, pop_flags;
  pix_win_t          job_win, pop_win;
  logic [CW-1:0]     job_col, pop_col;
  logic [RW-1:0]     job_row, pop_row;
  logic [DW-1:0]     push_data, pop_data;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= 12'd640;
      fh_r   <= 13'd480;
      thr_r  <= '0;
      gain_r <= 16'd256;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_FRAME_WIDTH) begin
        fw_r <= cfg_ch.data[11:0];
      end else if (cfg_ch.index == REG_FRAME_HEIGHT) begin
        fh_r <= cfg_ch.data[12:0];
      end else if (cfg_ch.index == REG_EDGE_THRESHOLD) begin
        thr_r <= cfg_ch.data[THR_W-1:0];
      end else if (cfg_ch.index == REG_GAIN) begin
        gain_r <= cfg_ch.data[GAIN_W-1:0];
      end
    end
  end

  // last column and row of the clamped frame size
  always_comb begin
    if (fw_r < 12'd3) begin
      wm1 = CW'(2);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(fw_r - 12'd1);
    end
    if (fh_r < 13'd3) begin
      hm1 = RW'(2);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(fh_r - 13'd1);
    end
  end

  sobel_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .RW        (RW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .wm1       (wm1),
    .hm1       (hm1),
    .q_ready   (q_ready),
    .push      (push),
    .job_flags (job_flags),
    .job_win   (job_win),
    .job_col   (job_col),
    .job_row   (job_row)
  );

  assign push_data = {job_flags, job_win, job_col, job_row};

  sobel_queue #(
    .DW    (DW),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  assign {pop_flags, pop_win, pop_col, pop_row} = pop_data;

  sobel_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_flags (pop_flags),
    .pop_win   (pop_win),
    .pop_col   (pop_col),
    .pop_row   (pop_row),
    .pop       (pop),
    .wm1       (wm1),
    .hm1       (hm1),
    .gain      (gain_r),
    .thr       (thr_r),
    .out_ch    (out_ch)
  );

  // checks
  `SOBEL_ASSERT_IMP(a_frame_done_last, out_ch.valid && out_ch.frame_done, out_ch.last_of_run, "frame_done without last_of_run")
  `SOBEL_ASSERT_IMP(a_border_zero, out_ch.valid && (out_ch.out_col == '0 || out_ch.out_row == '0), out_ch.edge_value == 8'd0, "nonzero edge on border")
  `SOBEL_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "front took two items back to back")
endmodule

// ===== rtl/sobel_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
module sobel_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output logic [DW-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

// ===== rtl/sobel_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_front
// accepts pixels, keeps line stores, window and position, classifies items
// ----------------------------------------------------------------------------
module sobel_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int CW        = 11,
  parameter int RW        = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pix_if.sink                       in_ch,
  input  logic [CW-1:0]             wm1,
  input  logic [RW-1:0]             hm1,
  input  logic                      q_ready,
  output logic                      push,
  output sobel_pkg::job_flags_t     job_flags,
  output sobel_pkg::pix_win_t       job_win,
  output logic [CW-1:0]             job_col,
  output logic [RW-1:0]             job_row
);
  import sobel_pkg::*;

  front_state_t     state_r, state_nxt;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [CW-1:0]    x;
  logic [RW-1:0]    y;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] up_rd_r, lo_rd_r;
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] up_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lo_mem [MAX_WIDTH];
  logic             accept, exec;

  // position saturated to the current frame size
  assign x = (col_r > wm1) ? wm1 : col_r;
  assign y = (row_r > hm1) ? hm1 : row_r;

  assign accept = in_ch.valid && in_ch.ready;
  assign exec   = (state_r == F_EXEC);

  // classification of the results this item causes
  always_comb begin
    job_flags.main     = (y != '0) && (x != '0);
    job_flags.interior = (y > RW'(1)) && (x > CW'(1));
    job_flags.right    = (y != '0) && (x == wm1);
    job_flags.bottom   = (y == hm1) && (x != '0);
    job_flags.corner   = (y == hm1) && (x == wm1);
  end

  // window as seen by the back part
  always_comb begin
    job_win[0] = win_r[0];
    job_win[3] = win_r[1];
    job_win[6] = win_r[2];
    job_win[1] = win_r[3];
    job_win[4] = win_r[4];
    job_win[7] = win_r[5];
    job_win[2] = up_rd_r;
    job_win[5] = lo_rd_r;
    job_win[8] = pix_r;
  end

  assign job_col = x - 1'b1;
  assign job_row = y - 1'b1;

  // sequencer: take item, update stores, let the read settle
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ch.ready = q_ready;
        if (accept) begin
          state_nxt = F_EXEC;
        end
      end
      F_EXEC: begin
        push      = job_flags.main || job_flags.right || job_flags.bottom ||
                    job_flags.corner;
        state_nxt = F_WAIT;
      end
      F_WAIT: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // line stores, registered read at the current column
  always_ff @(posedge clk) begin
    up_rd_r <= up_mem[x];
    lo_rd_r <= lo_mem[x];
    if (exec) begin
      up_mem[x] <= lo_rd_r;
      lo_mem[x] <= pix_r;
    end
  end

  // pixel latch
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_ch.pixel;
    end
  end

  // window shift and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      col_r <= '0;
      row_r <= '0;
    end else if (exec) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_rd_r;
      win_r[4] <= lo_rd_r;
      win_r[5] <= pix_r;
      if (x >= wm1) begin
        col_r <= '0;
        row_r <= (y >= hm1) ? '0 : y + 1'b1;
      end else begin
        col_r <= x + 1'b1;
        row_r <= y;
      end
    end
  end
endmodule

// ===== rtl/sobel_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_back
// gradient, bit-serial square root, gain, threshold and result emission
// ----------------------------------------------------------------------------
module sobel_back #(
  parameter int CW = 11,
  parameter int RW = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  input  sobel_pkg::job_flags_t         pop_flags,
  input  sobel_pkg::pix_win_t           pop_win,
  input  logic [CW-1:0]                 pop_col,
  input  logic [RW-1:0]                 pop_row,
  output logic                          pop,
  input  logic [CW-1:0]                 wm1,
  input  logic [RW-1:0]                 hm1,
  input  logic [sobel_pkg::GAIN_W-1:0]  gain,
  input  logic [sobel_pkg::THR_W-1:0]   thr,
  res_if.source                         out_ch
);
  import sobel_pkg::*;

  back_state_t               state_r, state_nxt;
  job_flags_t                flags_r;
  pix_win_t                  win_r;
  logic [CW-1:0]             col_r;
  logic [RW-1:0]             row_r;
  logic [3:0]                pend_r, pick, rest;
  logic signed [GRAD_W-1:0]  gx, gy, gx_r, gy_r;
  logic signed [SUMSQ_W-1:0] gx_sq, gy_sq;
  logic [SUMSQ_W-1:0]        sumsq;
  logic [RAD_W-1:0]          rad_r;
  logic [REM_W-1:0]          rem_r, rem_sh, trial;
  logic [ROOT_W-1:0]         root_r;
  logic [4:0]                step_r;
  logic [PROD_W-1:0]         prod;
  logic [SCALED_W-1:0]       scaled_r;
  logic [PIX_W-1:0]          value_r;
  logic                      out_valid_r, out_free, emit;

  function automatic logic signed [GRAD_W-1:0] diff(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
    diff = $signed({3'b000, a}) - $signed({3'b000, b});
  endfunction

  // kernels over the window
  assign gx = diff(win_r[6], win_r[0]) + (diff(win_r[7], win_r[1]) <<< 1) +
              diff(win_r[8], win_r[2]);
  assign gy = diff(win_r[2], win_r[0]) + (diff(win_r[5], win_r[3]) <<< 1) +
              diff(win_r[8], win_r[6]);

  // squares at full width, each at most 1020 squared
  assign gx_sq = gx_r * gx_r;
  assign gy_sq = gy_r * gy_r;
  assign sumsq = $unsigned(gx_sq) + $unsigned(gy_sq);

  // one root bit per step
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  assign prod = PROD_W'(root_r) * PROD_W'(gain);

  // lowest pending result goes first
  always_comb begin
    pick = 4'b0000;
    priority if (pend_r[0]) pick = 4'b0001;
    else if (pend_r[1]) pick = 4'b0010;
    else if (pend_r[2]) pick = 4'b0100;
    else if (pend_r[3]) pick = 4'b1000;
    else pick = 4'b0000;
  end
  assign rest     = pend_r & ~pick;
  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          pop       = 1'b1;
          state_nxt = pop_flags.interior ? B_GRAD : B_EMIT;
        end
      end
      B_GRAD: state_nxt = B_SQR;
      B_SQR:  state_nxt = B_ROOT;
      B_ROOT: begin
        if (step_r == 5'(ROOT_W - 1)) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL:  state_nxt = B_THR;
      B_THR:  state_nxt = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (rest == 4'b0000) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // job latch and arithmetic datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      flags_r <= pop_flags;
      win_r   <= pop_win;
      col_r   <= pop_col;
      row_r   <= pop_row;
      value_r <= '0;
    end
    if (state_r == B_GRAD) begin
      gx_r <= gx;
      gy_r <= gy;
    end
    if (state_r == B_SQR) begin
      rad_r  <= {1'b0, sumsq, 16'b0};
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end
    if (state_r == B_ROOT) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      step_r <= step_r + 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (state_r == B_MUL) begin
      scaled_r <= prod[PROD_W-1:8];
    end
    if (state_r == B_THR) begin
      if (scaled_r < SCALED_W'(thr)) begin
        value_r <= '0;
      end else if (scaled_r[SCALED_W-1:16] != '0) begin
        value_r <= 8'hff;
      end else begin
        value_r <= scaled_r[15:8];
      end
    end
  end

  // pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (pop) begin
      pend_r <= {pop_flags.corner, pop_flags.bottom, pop_flags.right, pop_flags.main};
    end else if (emit) begin
      pend_r <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.last_of_run <= (rest == 4'b0000);
      out_ch.frame_done  <= pick[3];
      out_ch.edge_value  <= (pick[0] && flags_r.interior) ? value_r : '0;
      out_ch.out_col     <= (pick[1] || pick[3]) ? wm1 : col_r;
      out_ch.out_row     <= (pick[2] || pick[3]) ? hm1 : row_r;
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule

// ===== bench/sobel_edge_threshold_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb
// self-checking bench: small frames of grey pixels go through the edge
// detector under several sizes, gains and thresholds; every result is checked
// against an in-bench model of the window, line stores and arithmetic
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;
  import sobel_pkg::*;

  localparam int MAX_W      = 2048;
  localparam int MAX_H      = 4096;
  localparam int STALL_MAX  = 5000;
  localparam int SETTLE_CYC = 40;
  // index past the end of the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef struct {
    logic [10:0] col;
    logic [11:0] row;
    logic [7:0]  val;
    logic        last;
    logic        fd;
  } edge_res_t;

  typedef struct {
    logic [7:0] pix;
    bit         known;
    logic [7:0] kval;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pix_if pix ();
  res_if res ();
  cfg_if cfg ();

  sobel_edge_threshold u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix),
    .out_ch (res),
    .cfg_ch (cfg)
  );

  // shadow of the block state
  logic [7:0]  row_m2 [MAX_W];
  logic [7:0]  row_m1 [MAX_W];
  logic [7:0]  win [6];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [11:0] cur_width;
  logic [12:0] cur_height;
  logic [19:0] cur_thresh;
  logic [15:0] cur_gain;

  edge_res_t edge_q[$];
  bit        frame_end;
  int        errs;
  int        pix_cnt;
  int        res_cnt;
  int        frame_cnt;
  int        send_idle_pct;
  int        rcv_stall_pct;
  int        stall_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sobel magnitude, gain, threshold and clamp
  function automatic logic [7:0] edge_strength(input int tl, input int tm, input int tr,
                                               input int ml, input int mr,
                                               input int bl, input int bm, input int br);
    int                 gx;
    int                 gy;
    longint unsigned    rad;
    longint unsigned    root;
    longint unsigned    trial;
    longint unsigned    scaled;
    gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
    gy = (bl + 2 * bm + br) - (tl + 2 * tm + tr);
    rad = longint'(gx * gx + gy * gy) << 16;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    scaled = (root * cur_gain) >> 8;
    if (scaled < cur_thresh) return 8'd0;
    scaled = scaled >> 8;
    return (scaled > 255) ? 8'd255 : scaled[7:0];
  endfunction

  function automatic void push_res(input int unsigned c, input int unsigned r,
                                   input logic [7:0] v, input logic fd);
    edge_res_t e;
    e.col  = c[10:0];
    e.row  = r[11:0];
    e.val  = v;
    e.last = 1'b0;
    e.fd   = fd;
    edge_q.push_back(e);
  endfunction

  // expected results of one accepted pixel
  task automatic predict_pixel(input logic [7:0] p, input bit known, input logic [7:0] kval);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    logic [7:0]  up;
    logic [7:0]  lo;
    logic [7:0]  v;
    int          first;
    w = (cur_width < 3) ? 3 : ((cur_width > MAX_W) ? MAX_W : cur_width);
    h = (cur_height < 3) ? 3 : ((cur_height > MAX_H) ? MAX_H : cur_height);
    if (col_pos > w - 1) col_pos = w - 1;
    if (row_pos > h - 1) row_pos = h - 1;
    x = col_pos;
    y = row_pos;
    up = row_m2[x];
    lo = row_m1[x];
    first = edge_q.size();
    if (y >= 1 && x >= 1) begin
      v = 8'd0;
      if (x >= 2 && y >= 2)
        v = edge_strength(win[0], win[3], up, win[1], lo, win[2], win[5], p);
      push_res(x - 1, y - 1, v, 1'b0);
    end
    if (y >= 1 && x == w - 1) push_res(w - 1, y - 1, 8'd0, 1'b0);
    if (y == h - 1 && x >= 1) push_res(x - 1, h - 1, 8'd0, 1'b0);
    if (y == h - 1 && x == w - 1) begin
      push_res(w - 1, h - 1, 8'd0, 1'b1);
      frame_end = 1'b1;
    end
    if (edge_q.size() > first) begin
      edge_q[edge_q.size() - 1].last = 1'b1;
      if (known) edge_q[first].val = kval;
    end
    // shift stores and window
    row_m2[x] = lo;
    row_m1[x] = p;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = lo;
    win[5] = p;
    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    pix_cnt++;
  endtask

  // one pixel through the input channel, with optional idle gap
  task automatic push_pixel(input logic [7:0] p, input bit known, input logic [7:0] kval);
    int gap;
    gap = 0;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    do @(posedge clk); while (!pix.ready);
    predict_pixel(p, known, kval);
  endtask

  // register write, valid stays high for back-to-back writes
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_FRAME_WIDTH:    cur_width  = data[11:0];
      REG_FRAME_HEIGHT:   cur_height = data[12:0];
      REG_EDGE_THRESHOLD: cur_thresh = data[19:0];
      REG_GAIN:           cur_gain   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] wd, input logic [31:0] ht,
                           input logic [31:0] th, input logic [31:0] gn);
    reg_write(REG_FRAME_WIDTH, wd);
    reg_write(REG_FRAME_HEIGHT, ht);
    reg_write(REG_EDGE_THRESHOLD, th);
    reg_write(REG_GAIN, gn);
    cfg.valid <= 1'b0;
  endtask

  // wait until every expected item has come and the block has gone quiet
  task automatic settle();
    pix.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct = 73; rcv_stall_pct = 0; end
      2: begin send_idle_pct = 0; rcv_stall_pct = 73; end
      3: begin send_idle_pct = 34; rcv_stall_pct = 34; end
      default: begin send_idle_pct = 0; rcv_stall_pct = 0; end
    endcase
  endtask

  function automatic logic [7:0] pick_pixel(input int style);
    case (style)
      0: return $urandom_range(255);
      1: return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
      default: return 8'(col_pos * 37 + row_pos * 11 + $urandom_range(15));
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    res.ready <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    edge_res_t e;
    if (rst_n) begin
      if (res.valid && res.ready) begin
        res_cnt++;
        if (edge_q.size() == 0) begin
          $error("result item with nothing expected: col %0d row %0d", res.out_col, res.out_row);
          errs++;
        end else begin
          e = edge_q.pop_front();
          if (res.out_col !== e.col) begin
            $error("out_col expected %0d actual %0d", e.col, res.out_col); errs++;
          end
          if (res.out_row !== e.row) begin
            $error("out_row expected %0d actual %0d", e.row, res.out_row); errs++;
          end
          if (res.edge_value !== e.val) begin
            $error("edge_value expected %0d actual %0d", e.val, res.edge_value); errs++;
          end
          if (res.last_of_run !== e.last) begin
            $error("last_of_run expected %0d actual %0d", e.last, res.last_of_run); errs++;
          end
          if (res.frame_done !== e.fd) begin
            $error("frame_done expected %0d actual %0d", e.fd, res.frame_done); errs++;
          end
        end
      end
      if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("watchdog: no handshake for %0d cycles, %0d items pending",
                 STALL_MAX, edge_q.size());
        $display("sobel_edge_threshold: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t dir_tab [18];
    int        style;
    int        rand_pix;
    int        sel;
    logic [31:0] wd;
    logic [31:0] ht;
    logic [31:0] th;
    logic [31:0] gn;

    pix.valid = 1'b0;
    pix.pixel = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    res.ready = 1'b0;
    rst_n     = 1'b0;
    errs = 0; pix_cnt = 0; res_cnt = 0; frame_cnt = 0; stall_cnt = 0;
    send_idle_pct = 0; rcv_stall_pct = 0;
    foreach (row_m2[i]) begin
      row_m2[i] = '0;
      row_m1[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos = 0; row_pos = 0;
    cur_width = 12'd640; cur_height = 13'd480; cur_thresh = '0; cur_gain = 16'd256;

    // flat frame gives zero everywhere, step frame saturates the center
    for (int i = 0; i < 9; i++) dir_tab[i] = '{8'd128, 1'b1, 8'd0};
    for (int i = 0; i < 9; i++)
      dir_tab[9 + i] = '{(i % 3 == 0) ? 8'd0 : ((i % 3 == 1) ? 8'd128 : 8'd255), 1'b1, 8'd0};
    dir_tab[17].kval = 8'd255;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the smallest size
    write_all(32'd3, 32'd3, 32'd0, 32'd256);
    foreach (dir_tab[i]) push_pixel(dir_tab[i].pix, dir_tab[i].known, dir_tab[i].kval);
    frame_cnt += 2;
    settle();

    // ignored register index
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg.valid <= 1'b0;

    // random frames
    rand_pix = pix_cnt;
    while (pix_cnt - rand_pix < 300) begin
      set_idling(frame_cnt % 4);
      sel = frame_cnt % 8;
      wd = (sel == 3) ? $urandom_range(2) : $urandom_range(3, 9);
      ht = (sel == 5) ? $urandom_range(2) : $urandom_range(3, 6);
      case (sel)
        1: begin th = 32'hFFFFF; gn = 32'hFFFF; end
        2: begin th = 32'd0; gn = 32'd0; end
        4: begin th = 32'd0; gn = 32'hFFFF; end
        default: begin th = $urandom_range(131071); gn = $urandom_range(1023); end
      endcase
      write_all(wd, ht, th, gn);
      style = $urandom_range(2);
      frame_end = 1'b0;
      if (frame_cnt == 6) begin
        // shrink the frame mid-way, counters must saturate
        write_all(32'd7, 32'd6, th, 32'd256);
        for (int i = 0; i < 17; i++) push_pixel(pick_pixel(style), 1'b0, 8'd0);
        settle();
        write_all(32'd3, 32'd4, th, 32'd256);
      end
      while (!frame_end) push_pixel(pick_pixel(style), 1'b0, 8'd0);
      frame_cnt++;
      settle();
    end

    $display("run covered %0d frames, %0d pixels and %0d results", frame_cnt, pix_cnt, res_cnt);
    $display("sizes from clamped minimum to nine columns, one mid-frame shrink, gain and threshold at both ends");
    if (errs == 0 && edge_q.size() == 0) begin
      $display("sobel_edge_threshold: match");
    end else begin
      $display("sobel_edge_threshold: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sobel_pkg.sv
rtl/pix_if.sv
rtl/res_if.sv
rtl/cfg_if.sv
rtl/sobel_queue.sv
rtl/sobel_front.sv
rtl/sobel_back.sv
rtl/sobel_edge_threshold.sv
bench/sobel_edge_threshold_tb.sv
